// ----- rtl/swm_pkg.sv -----
// Shared types and constants of the sliding window maximum unit.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package swm_pkg;

	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int WINDOW_SIZE_W = 7;

	localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 7'd3;

	typedef enum logic [0:0] {
		REG_WINDOW_SIZE = 1'b0
	} reg_index_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

// ----- rtl/swm_cfg.sv -----
// Configuration register file of the sliding window maximum unit.
// Depends on swm_pkg for the register map and reset value.
`timescale 1ns / 1ps

module swm_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [swm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [swm_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                  pready,
	output logic [swm_pkg::WINDOW_SIZE_W-1:0]     window_size
);
	import swm_pkg::*;

	logic                     wr_en;
	reg_index_t               reg_idx;
	logic [WINDOW_SIZE_W-1:0] window_size_q;

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RST;
		end else if (wr_en && reg_idx == REG_WINDOW_SIZE) begin
			window_size_q <= pwdata[WINDOW_SIZE_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW_SIZE: prdata = {{(CFG_DATA_W-WINDOW_SIZE_W){1'b0}}, window_size_q};
			default:         prdata = '0;
		endcase
	end

	assign window_size = window_size_q;

endmodule

// ----- rtl/swm_cell.sv -----
// One candidate cell: holds a sample, its age and a valid bit.
// Compares against the new word, appends at the list boundary, shifts toward the head.
// Depends on swm_pkg for the control struct.
`timescale 1ns / 1ps

module swm_cell #(
	parameter int SAMPLE_BITS = 32,
	parameter int AGE_W       = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::cell_ctrl_t           ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          left_kept,
	input  logic signed [SAMPLE_BITS-1:0] right_val,
	input  logic [AGE_W-1:0]              right_age,
	input  logic                          right_valid,
	output logic                          kept,
	output logic signed [SAMPLE_BITS-1:0] fwd_val,
	output logic [AGE_W-1:0]              fwd_age,
	output logic                          fwd_valid,
	output logic signed [SAMPLE_BITS-1:0] q_val,
	output logic [AGE_W-1:0]              q_age,
	output logic                          q_valid
);
	import swm_pkg::*;

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic [AGE_W-1:0]              age_q;
	logic                          valid_q;
	logic                          boundary;

	assign kept     = ctrl.step & valid_q & ~ctrl.clear & (val_q > sample);
	assign boundary = ctrl.step & left_kept & ~kept;

	always_comb begin
		if (ctrl.step) begin
			fwd_valid = kept | boundary;
			fwd_val   = kept ? val_q : sample;
			fwd_age   = kept ? age_q + AGE_W'(1) : '0;
		end else begin
			fwd_valid = valid_q;
			fwd_val   = val_q;
			fwd_age   = age_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.step) begin
			valid_q <= fwd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= right_val;
			age_q <= right_age;
		end else if (ctrl.step) begin
			val_q <= fwd_val;
			age_q <= fwd_age;
		end
	end

	assign q_val   = val_q;
	assign q_age   = age_q;
	assign q_valid = valid_q;

endmodule

// ----- rtl/sliding_window_maximum_unit.sv -----
// Top level of the sliding window maximum unit: a row of candidate cells,
// the configuration port and the result register.
// Depends on swm_pkg, swm_cfg and swm_cell.
//
//   channel  direction  handshake            payload
//   in       in         in_valid / in_stall  sample, first_of_sequence
//   out      out        out_valid / out_stall window_max
//   cfg      in         APB write / read     window_size
//
// Once the window has filled, a taken word's result goes to the output register, or
// is held pending while aged head candidates drop. After the window is shrunk,
// candidates beyond the new window drop at the head, one head drop per cycle, before
// the next word is taken. Reset clears all valid bits at once, with no clearing pass.
// The input stalls while a result waits in the output register and out_stall is high.
`timescale 1ns / 1ps

module sliding_window_maximum_unit #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  first_of_sequence,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [SAMPLE_BITS-1:0]         window_max,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [swm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [swm_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                  pready
);
	import swm_pkg::*;

	localparam int AGE_W = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W = (AGE_W > WINDOW_SIZE_W) ? AGE_W : WINDOW_SIZE_W;

	logic [WINDOW_SIZE_W-1:0]      window_size;
	logic [CMP_W-1:0]              win_ext;
	logic [CMP_W-1:0]              win_sat;
	logic [AGE_W-1:0]              w_eff;

	cell_ctrl_t                    ctrl;
	logic                          step;
	logic                          step_shift;
	logic                          head_aged;

	logic signed [SAMPLE_BITS-1:0] fwd_val   [0:WINDOW_MAX];
	logic [AGE_W-1:0]              fwd_age   [0:WINDOW_MAX];
	logic                          fwd_valid [0:WINDOW_MAX];
	logic                          kept      [0:WINDOW_MAX-1];
	logic signed [SAMPLE_BITS-1:0] q_val     [0:WINDOW_MAX-1];
	logic [AGE_W-1:0]              q_age     [0:WINDOW_MAX-1];
	logic [WINDOW_MAX-1:0]         vld_vec;

	logic signed [SAMPLE_BITS-1:0] head_next_val;
	logic [AGE_W-1:0]              head_next_age;
	logic                          head_next_aged;

	logic [AGE_W-1:0]              seen_q;
	logic [AGE_W-1:0]              seen_base;
	logic [AGE_W-1:0]              seen_inc;
	logic                          emit;

	logic                          pend_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] window_max_q;
	logic                          out_free;

	swm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.window_size (window_size)
	);

	always_comb begin
		win_ext = CMP_W'(window_size);
		if (window_size == '0) begin
			win_sat = CMP_W'(1);
		end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
			win_sat = CMP_W'(WINDOW_MAX);
		end else begin
			win_sat = win_ext;
		end
	end

	assign w_eff = win_sat[AGE_W-1:0];

	genvar i;
	generate
		for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
			logic left_kept;

			if (i == 0) begin : g_head
				assign left_kept = 1'b1;
			end else begin : g_body
				assign left_kept = kept[i-1];
			end

			swm_cell #(
				.SAMPLE_BITS (SAMPLE_BITS),
				.AGE_W       (AGE_W)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.sample      (sample),
				.left_kept   (left_kept),
				.right_val   (fwd_val[i+1]),
				.right_age   (fwd_age[i+1]),
				.right_valid (fwd_valid[i+1]),
				.kept        (kept[i]),
				.fwd_val     (fwd_val[i]),
				.fwd_age     (fwd_age[i]),
				.fwd_valid   (fwd_valid[i]),
				.q_val       (q_val[i]),
				.q_age       (q_age[i]),
				.q_valid     (vld_vec[i])
			);
		end
	endgenerate

	// Past the last cell the new word lands only when every cell keeps its candidate.
	assign fwd_valid[WINDOW_MAX] = step & kept[WINDOW_MAX-1];
	assign fwd_val[WINDOW_MAX]   = sample;
	assign fwd_age[WINDOW_MAX]   = '0;

	assign head_aged  = vld_vec[0] & (q_age[0] >= w_eff);
	assign out_free   = ~out_valid_q | ~out_stall;
	assign in_stall   = head_aged | pend_q | ~out_free;
	assign step       = in_valid & ~in_stall;
	assign step_shift = fwd_age[0] >= w_eff;

	assign ctrl.step  = step;
	assign ctrl.clear = first_of_sequence;
	assign ctrl.shift = step ? step_shift : head_aged;

	assign head_next_val  = step_shift ? fwd_val[1] : fwd_val[0];
	assign head_next_age  = step_shift ? fwd_age[1] : fwd_age[0];
	assign head_next_aged = head_next_age >= w_eff;

	assign seen_base = first_of_sequence ? '0 : seen_q;
	assign seen_inc  = (seen_base < AGE_W'(WINDOW_MAX)) ? seen_base + AGE_W'(1) : seen_base;
	assign emit      = seen_inc >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (step) begin
			seen_q <= seen_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (step && emit && !head_next_aged) begin
			out_valid_q <= 1'b1;
		end else if (step && emit) begin
			pend_q <= 1'b1;
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end else if (pend_q && !head_aged && out_free) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit && !head_next_aged) begin
			window_max_q <= head_next_val;
		end else if (pend_q && !head_aged && out_free) begin
			window_max_q <= q_val[0];
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	// Valid candidates always form a prefix of the cell row.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec >> 1) & ~vld_vec) == '0)
		else $error("candidate valid bits are not a prefix");

	// A new sequence leaves exactly one candidate, in the head cell.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && first_of_sequence |=> vld_vec == WINDOW_MAX'(1))
		else $error("new sequence did not clear the window");

	// A pending result is delivered once the head has settled and the register is free.
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !head_aged && out_free |=> out_valid_q && !pend_q)
		else $error("pending result not delivered");

endmodule
